// ===== hw/rtl/hsd_pkg.sv =====
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types and constants for the header-synchronised packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hsd_pkg;

    localparam int BODY_LEN   = 6;
    localparam int BODY_IDX_W = $clog2(BODY_LEN);
    localparam int BYTE_W     = 8;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [BODY_IDX_W-1:0] t_body_idx;
    typedef t_byte [BODY_LEN-1:0] t_body;

    // Register indexes of the configuration port
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HEADER = 1'b0;
    localparam t_cfg_idx CFG_DEVICE = 1'b1;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_DEV   = 4'd1,
        PH_BODY0 = 4'd2,
        PH_BODY1 = 4'd3,
        PH_BODY2 = 4'd4,
        PH_BODY3 = 4'd5,
        PH_BODY4 = 4'd6,
        PH_BODY5 = 4'd7,
        PH_CHECK = 4'd8
    } t_phase;

    // Result of one accepted byte, tracker to output stage
    typedef struct packed {
        logic  valid;
        t_body body;
        logic  ok;
    } t_trk_res;

endpackage

`default_nettype wire

// ===== hw/rtl/hsd_tracker.sv =====
// ----------------------------------------------------------------------------
// hsd_tracker
// Frame phase tracking, body capture and running checksum for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module hsd_tracker
    import hsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_accept,
    input  wire t_byte    i_byte,
    input  wire t_byte    i_header,
    input  wire t_byte    i_device,
    output t_trk_res      o_res
);

    t_phase    r_phase;
    t_phase    n_phase;
    t_byte     r_sum;
    t_byte     n_sum;
    t_byte     r_body [BODY_LEN];
    logic      body_we;
    t_body_idx body_idx;
    logic      sum_clr;
    logic      sum_add;
    logic      res_valid;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                PH_DEV: begin
                    if (i_byte == i_device) begin
                        n_phase = PH_BODY0;
                    end else if (i_byte == i_header) begin
                        n_phase = PH_DEV;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_BODY0, PH_BODY1, PH_BODY2, PH_BODY3, PH_BODY4, PH_BODY5: begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end
                PH_CHECK: begin
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = (i_byte == i_header) ? PH_DEV : PH_HUNT;
                end
            endcase
        end
    end

    // datapath controls
    always_comb begin
        body_we   = 1'b0;
        sum_clr   = 1'b0;
        sum_add   = 1'b0;
        body_idx  = t_body_idx'(r_phase[2:0] - 3'd2);
        res_valid = 1'b0;
        unique case (r_phase)
            PH_DEV: begin
                sum_clr = i_accept && (i_byte != i_device) && (i_byte == i_header);
            end
            PH_BODY0, PH_BODY1, PH_BODY2, PH_BODY3, PH_BODY4, PH_BODY5: begin
                body_we = i_accept;
                sum_add = i_accept;
            end
            PH_CHECK: begin
                sum_clr   = i_accept;
                res_valid = i_accept;
            end
            default: begin
                sum_clr = i_accept && (i_byte == i_header);
            end
        endcase
    end

    always_comb begin
        n_sum = r_sum;
        if (sum_clr) begin
            n_sum = '0;
        end else if (sum_add) begin
            n_sum = r_sum + i_byte;
        end
    end

    always_comb begin
        o_res.valid = res_valid;
        for (int k = 0; k < BODY_LEN; k++) begin
            o_res.body[k] = r_body[k];
        end
        o_res.ok = (r_sum == i_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (body_we) begin
            r_body[body_idx] <= i_byte;
        end
    end

`ifndef SYNTH
    a_check_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_CHECK) |=> (r_phase == PH_HUNT) && (r_sum == '0))
        else $error("phase did not return to hunting after checksum");

    a_dev_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_DEV) && (i_byte == i_device) |=> (r_phase == PH_BODY0))
        else $error("device match did not start body");

    a_body_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_BODY0) |=> (r_sum == $past(i_byte)))
        else $error("running sum wrong after first body byte");

    a_hunt_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_phase == PH_HUNT) && (i_byte != i_header) |=> (r_phase == PH_HUNT))
        else $error("left hunting without a header");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/header_sync_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// header_sync_packet_deframer
// Fixed 9-byte frame finder with additive body checksum.
// ----------------------------------------------------------------------------
// One received byte is taken per request, one per clock cycle while input is
// not stalled; the frame phase, running sum and body capture all update in the
// cycle a byte is accepted. On the checksum byte the body and a pass/fail flag
// are loaded into a single output register, so a result appears in the cycle
// after its checksum byte. Input is stalled only while that register holds a
// stalled result. The user writes header and device values through the
// configuration port only while the block is idle; the block does not enforce it.
`default_nettype none

module header_sync_packet_deframer
    import hsd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_byte    i_rx_byte,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_byte         o_resp_code,
    output t_byte         o_body_b1,
    output t_byte         o_body_b2,
    output t_byte         o_body_b3,
    output t_byte         o_body_b4,
    output t_byte         o_body_b5,
    output logic          o_checksum_ok,
    input  wire logic     i_cfg_we,
    input  wire t_cfg_idx i_cfg_index,
    input  wire t_byte    i_cfg_data
);

    t_byte    r_header;
    t_byte    r_device;
    logic     r_out_valid;
    t_body    r_out_body;
    logic     r_out_ok;
    logic     in_accept;
    t_trk_res trk_res;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= '0;
            r_device <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADER: r_header <= i_cfg_data;
                CFG_DEVICE: r_device <= i_cfg_data;
            endcase
        end
    end

    hsd_tracker u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_rx_byte),
        .i_header (r_header),
        .i_device (r_device),
        .o_res    (trk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (trk_res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (trk_res.valid) begin
            r_out_body <= trk_res.body;
            r_out_ok   <= trk_res.ok;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_resp_code   = r_out_body[0];
    assign o_body_b1     = r_out_body[1];
    assign o_body_b2     = r_out_body[2];
    assign o_body_b3     = r_out_body[3];
    assign o_body_b4     = r_out_body[4];
    assign o_body_b5     = r_out_body[5];
    assign o_checksum_ok = r_out_ok;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !trk_res.valid)
        else $error("held result overwritten");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trk_res.valid |=> o_out_valid && (o_resp_code == $past(trk_res.body[0])))
        else $error("result not loaded");

    a_cfg_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == CFG_HEADER) |=> (r_header == $past(i_cfg_data)))
        else $error("header register write lost");
`endif

endmodule

`default_nettype wire
